/* hw/rtl/hbfd_pkg.sv */
// Shared types and constants of the heartbeat failure detector.
package hbfd_pkg;

   localparam int SLOTS = 32;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = ($clog2(SLOTS + 1) > 6) ? $clog2(SLOTS + 1) : 6;

   localparam logic [31:0] SUSPECT_RESET = 32'd5000;
   localparam logic [31:0] DEAD_RESET    = 32'd15000;

   localparam logic [1:0] FUNC_ADD       = 2'd0;
   localparam logic [1:0] FUNC_REMOVE    = 2'd1;
   localparam logic [1:0] FUNC_HEARTBEAT = 2'd2;
   localparam logic [1:0] FUNC_CHECK     = 2'd3;

   localparam logic [1:0] KIND_STATUS  = 2'd0;
   localparam logic [1:0] KIND_CHANGE  = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   localparam logic [1:0] LIVE_ALIVE   = 2'd0;
   localparam logic [1:0] LIVE_SUSPECT = 2'd1;
   localparam logic [1:0] LIVE_DEAD    = 2'd2;

   localparam logic REG_SUSPECT = 1'b0;
   localparam logic REG_DEAD    = 1'b1;

   typedef struct packed {
      logic [15:0] ident;
      logic [1:0]  liveness;
      logic [31:0] seen_ms;
   } slot_entry_type;

   typedef struct packed {
      logic load_req;
      logic issue_first;
      logic scan_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic last_slot;
      logic stall;
      logic out_full;
   } sts_type;

endpackage

/* hw/rtl/hbfd_if.sv */
// Handshake interfaces of the request and response channels.
interface hbfd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  func;
   logic [15:0] node_ident;
   logic [31:0] now_ms;
   modport source (output valid, func, node_ident, now_ms, input ready);
   modport sink (input valid, func, node_ident, now_ms, output ready);
endinterface

interface hbfd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  result_kind;
   logic [1:0]  op_status;
   logic [15:0] changed_node;
   logic [1:0]  new_state;
   logic [5:0]  change_count;
   logic        last;
   modport source (output valid, result_kind, op_status, changed_node, new_state,
                   change_count, last, input ready);
   modport sink (input valid, result_kind, op_status, changed_node, new_state,
                 change_count, last, output ready);
endinterface

/* hw/rtl/hbfd_ram.sv */
// Generic single-port-write, registered-read RAM.
module hbfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data_ff
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end
endmodule

/* hw/rtl/hbfd_ctrl.sv */
// Sequencer for one request: latch, slot scan, final result.
module hbfd_ctrl (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  hbfd_pkg::sts_type sts,
   output hbfd_pkg::cmd_type cmd
);
   import hbfd_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_START  = 2'd1;
   localparam logic [1:0] ST_SCAN   = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_START;
            end
         end
         ST_START: begin
            cmd.issue_first = 1'b1;
            state_in        = ST_SCAN;
         end
         ST_SCAN: begin
            if (!sts.stall) begin
               cmd.scan_step = 1'b1;
               if (sts.last_slot) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (!sts.out_full) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

/* hw/rtl/hbfd_dpath.sv */
// Slot table, timeout registers, scan bookkeeping and result register.
module hbfd_dpath (
   input  logic              clock,
   input  logic              reset,
   input  hbfd_pkg::cmd_type cmd,
   output hbfd_pkg::sts_type sts,
   input  logic [1:0]        req_func,
   input  logic [15:0]       req_node_ident,
   input  logic [31:0]       req_now_ms,
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [31:0]       csr_write_data,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic [1:0]        rsp_result_kind,
   output logic [1:0]        rsp_op_status,
   output logic [15:0]       rsp_changed_node,
   output logic [1:0]        rsp_new_state,
   output logic [5:0]        rsp_change_count,
   output logic              rsp_last
);
   import hbfd_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   logic [31:0]      suspect_ff, dead_ff;
   logic [SLOTS-1:0] valid_ff, valid_in;
   logic [1:0]       func_ff;
   logic [15:0]      id_ff;
   logic [31:0]      now_ff;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             found_ff, found_in, free_ff, free_in;
   logic [IDX_W-1:0] found_idx_ff, found_idx_in, free_idx_ff, free_idx_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic             out_valid_ff, out_valid_in;
   logic [1:0]       out_kind_ff, out_kind_in, out_status_ff, out_status_in;
   logic [15:0]      out_node_ff, out_node_in;
   logic [1:0]       out_state_ff, out_state_in;
   logic [5:0]       out_count_ff, out_count_in;
   logic             out_last_ff, out_last_in;

   slot_entry_type   rd_data, wr_data;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr, rd_addr;
   logic             slot_v, change, out_full;
   logic [31:0]      silence;
   logic [1:0]       nxt;

   hbfd_ram #(.WIDTH($bits(slot_entry_type)), .DEPTH(SLOTS)) u_ram (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   assign slot_v   = valid_ff[idx_ff];
   assign silence  = now_ff - rd_data.seen_ms;
   assign out_full = out_valid_ff && !rsp_ready;

   always_comb begin
      nxt = rd_data.liveness;
      if (rd_data.liveness == LIVE_ALIVE && silence > suspect_ff) begin
         nxt = LIVE_SUSPECT;
      end else if (rd_data.liveness == LIVE_SUSPECT && silence > dead_ff) begin
         nxt = LIVE_DEAD;
      end
   end

   assign change = (func_ff == FUNC_CHECK) && slot_v && (nxt != rd_data.liveness);

   assign sts.last_slot = (idx_ff == LAST_IDX);
   assign sts.stall     = change && out_full;
   assign sts.out_full  = out_full;

   always_comb begin
      if (cmd.issue_first) begin
         rd_addr = '0;
      end else if (cmd.scan_step) begin
         rd_addr = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
      end else begin
         rd_addr = idx_ff;
      end
   end

   always_comb begin
      valid_in      = valid_ff;
      idx_in        = idx_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      cnt_in        = cnt_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = '{ident: rd_data.ident, liveness: nxt, seen_ms: rd_data.seen_ms};
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_kind_in   = out_kind_ff;
      out_status_in = out_status_ff;
      out_node_in   = out_node_ff;
      out_state_in  = out_state_ff;
      out_count_in  = out_count_ff;
      out_last_in   = out_last_ff;

      if (cmd.issue_first) begin
         idx_in   = '0;
         found_in = 1'b0;
         free_in  = 1'b0;
         cnt_in   = '0;
      end

      if (cmd.scan_step) begin
         idx_in = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
         if (slot_v && rd_data.ident == id_ff && !found_ff) begin
            found_in     = 1'b1;
            found_idx_in = idx_ff;
         end
         if (!slot_v && !free_ff) begin
            free_in     = 1'b1;
            free_idx_in = idx_ff;
         end
         if (change) begin
            wr_en         = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            out_valid_in  = 1'b1;
            out_kind_in   = KIND_CHANGE;
            out_status_in = STATUS_OK;
            out_node_in   = rd_data.ident;
            out_state_in  = nxt;
            out_count_in  = '0;
            out_last_in   = 1'b0;
         end
      end

      if (cmd.finish) begin
         out_valid_in  = 1'b1;
         out_kind_in   = KIND_STATUS;
         out_status_in = STATUS_OK;
         out_node_in   = '0;
         out_state_in  = LIVE_ALIVE;
         out_count_in  = '0;
         out_last_in   = 1'b1;
         wr_data       = '{ident: id_ff, liveness: LIVE_ALIVE, seen_ms: now_ff};
         unique case (func_ff)
            FUNC_CHECK: begin
               out_kind_in  = KIND_SUMMARY;
               out_count_in = cnt_ff[5:0];
            end
            FUNC_ADD: begin
               if (!found_ff) begin
                  if (free_ff) begin
                     valid_in[free_idx_ff] = 1'b1;
                     wr_en   = 1'b1;
                     wr_addr = free_idx_ff;
                  end else begin
                     out_status_in = STATUS_FULL;
                  end
               end
            end
            FUNC_REMOVE: begin
               if (found_ff) begin
                  valid_in[found_idx_ff] = 1'b0;
               end else begin
                  out_status_in = STATUS_NOT_FOUND;
               end
            end
            FUNC_HEARTBEAT: begin
               if (found_ff) begin
                  wr_en   = 1'b1;
                  wr_addr = found_idx_ff;
               end else begin
                  out_status_in = STATUS_NOT_FOUND;
               end
            end
            default: out_status_in = STATUS_OK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         suspect_ff   <= SUSPECT_RESET;
         dead_ff      <= DEAD_RESET;
         valid_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index)
               REG_SUSPECT: suspect_ff <= csr_write_data;
               REG_DEAD:    dead_ff    <= csr_write_data;
               default:     suspect_ff <= suspect_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         func_ff <= req_func;
         id_ff   <= req_node_ident;
         now_ff  <= req_now_ms;
      end
      idx_ff        <= idx_in;
      found_ff      <= found_in;
      found_idx_ff  <= found_idx_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      cnt_ff        <= cnt_in;
      out_kind_ff   <= out_kind_in;
      out_status_ff <= out_status_in;
      out_node_ff   <= out_node_in;
      out_state_ff  <= out_state_in;
      out_count_ff  <= out_count_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_result_kind  = out_kind_ff;
   assign rsp_op_status    = out_status_ff;
   assign rsp_changed_node = out_node_ff;
   assign rsp_new_state    = out_state_ff;
   assign rsp_change_count = out_count_ff;
   assign rsp_last         = out_last_ff;
endmodule

/* hw/rtl/heartbeat_failure_detector.sv */
// Top level of the heartbeat timeout failure detector.
//
// The block keeps a table of up to SLOTS tracked nodes. Each request item on
// the req_chan channel carries one operation: add, remove, heartbeat or check.
// Add, remove and heartbeat answer with one status item on rsp_chan. Check
// ages every valid node by the silence since its last heartbeat and answers
// with one item per liveness change, in slot order, then one summary item
// that carries the change count. The final item of each request has last set.
// The two timeout registers are to be written by the user through the csr_ port
// only while idle; the block itself does not enforce this.
//
// Every request walks the whole slot table one slot per cycle, unless a change
// item waits on a stalled receiver, through the single read port of the slot
// memory, going from idle through the start, scan and finish states back to
// idle; a new request is accepted only in idle.
//
// Reset clears all slot valid bits and restores the timeouts to 5000 and
// 15000 ms; no clearing pass is needed. When the receiver stalls, the result
// register holds its item and the scan pauses on the slot that has the next
// result, so nothing is lost or reordered.
module heartbeat_failure_detector (
   input  logic              clock,
   input  logic              reset,
   hbfd_req_if.sink          req_chan,
   hbfd_rsp_if.source        rsp_chan,
   input  logic              csr_write_enable,
   input  logic              csr_index,
   input  logic [31:0]       csr_write_data
);
   import hbfd_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // The controller owns the request handshake and sequences the scan.
   hbfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the slot table, the timeouts and the result register.
   hbfd_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_func         (req_chan.func),
      .req_node_ident   (req_chan.node_ident),
      .req_now_ms       (req_chan.now_ms),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_result_kind  (rsp_chan.result_kind),
      .rsp_op_status    (rsp_chan.op_status),
      .rsp_changed_node (rsp_chan.changed_node),
      .rsp_new_state    (rsp_chan.new_state),
      .rsp_change_count (rsp_chan.change_count),
      .rsp_last         (rsp_chan.last)
   );

   // A request occupies the block for a full scan, so no second accept follows.
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted while a scan is running");

   // A summary item always closes a check.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.result_kind == KIND_SUMMARY) |-> rsp_chan.last)
      else $error("summary item without last");

   // A change item never closes a request and never reports a node as alive.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.result_kind == KIND_CHANGE)
      |-> (!rsp_chan.last && rsp_chan.new_state != LIVE_ALIVE))
      else $error("malformed change item");

   // No result item is presented right after reset.
   assert property (@(posedge clock) reset |=> !rsp_chan.valid)
      else $error("result valid after reset");
endmodule

/* verif/tb.sv */
// Self-checking testbench of the heartbeat failure detector.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hbfd_pkg::*;

   // One result item as the block presents it on the response channel.
   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [15:0] node;
      logic [1:0]  state;
      logic [5:0]  count;
      logic        last;
   } result_type;

   // One row of the directed stimulus. A row with typed set carries its own
   // status; all other rows are checked against the shadow table.
   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] ident;
      logic [31:0] now_ms;
      logic        typed;
      logic [1:0]  status;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 14;
   localparam int POOL_SIZE = 40;
   localparam int PHASES = 8;
   localparam int ITEMS_PER_PHASE = 23;
   // Enough cycles for one request to finish its slot walk.
   localparam int DRAIN_CYCLES = 40;

   localparam int IDLE_NONE = 0;
   localparam int IDLE_SENDER = 1;
   localparam int IDLE_RECEIVER = 2;
   localparam int IDLE_BOTH = 3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable;
   logic        csr_index;
   logic [31:0] csr_write_data;

   hbfd_req_if req_chan ();
   hbfd_rsp_if rsp_chan ();

   heartbeat_failure_detector DUT (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan.sink),
      .rsp_chan         (rsp_chan.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #4 clock = ~clock;

   // Shadow copy of the node table and the two timeout registers.
   logic        node_valid [SLOTS];
   logic [15:0] node_ident [SLOTS];
   logic [1:0]  node_live [SLOTS];
   logic [31:0] node_seen [SLOTS];
   logic [31:0] suspect_limit;
   logic [31:0] dead_limit;

   // Results the block still owes, oldest first.
   result_type pending_results[$];
   int mismatches = 0;
   int idle_mode = IDLE_NONE;
   logic [15:0] id_pool [POOL_SIZE];

   task automatic report_mismatch(input string what, input result_type got,
                                  input result_type want);
      $display("MISMATCH %0t: %s got %p expected %p", $realtime, what, got, want);
      mismatches++;
   endtask

   // Applies one accepted item to the shadow table and queues the results it
   // causes. Typed rows replace the computed status by the one in the table.
   function automatic void detector_predict(input logic [1:0] func,
                                            input logic [15:0] ident,
                                            input logic [31:0] now_ms,
                                            input logic typed,
                                            input logic [1:0] typed_status);
      result_type r;
      int hit;
      int changes;
      logic [31:0] silence;
      logic [1:0] next_live;
      hit = -1;
      changes = 0;
      r = '0;
      if (func == FUNC_CHECK) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (node_valid[i]) begin
               silence = now_ms - node_seen[i];
               next_live = node_live[i];
               if (node_live[i] == LIVE_ALIVE && silence > suspect_limit)
                  next_live = LIVE_SUSPECT;
               else if (node_live[i] == LIVE_SUSPECT && silence > dead_limit)
                  next_live = LIVE_DEAD;
               if (next_live != node_live[i]) begin
                  node_live[i] = next_live;
                  r = '0;
                  r.kind = KIND_CHANGE;
                  r.node = node_ident[i];
                  r.state = next_live;
                  pending_results.push_back(r);
                  changes++;
               end
            end
         end
         r = '0;
         r.kind = KIND_SUMMARY;
         r.count = changes[5:0];
         r.last = 1'b1;
         pending_results.push_back(r);
         return;
      end
      for (int i = 0; i < SLOTS; i++)
         if (hit < 0 && node_valid[i] && node_ident[i] == ident)
            hit = i;
      r.kind = KIND_STATUS;
      r.status = STATUS_OK;
      r.last = 1'b1;
      if (func == FUNC_ADD) begin
         if (hit < 0) begin
            r.status = STATUS_FULL;
            for (int j = 0; j < SLOTS; j++) begin
               if (r.status == STATUS_FULL && !node_valid[j]) begin
                  node_valid[j] = 1'b1;
                  node_ident[j] = ident;
                  node_live[j] = LIVE_ALIVE;
                  node_seen[j] = now_ms;
                  r.status = STATUS_OK;
               end
            end
         end
      end else if (func == FUNC_REMOVE) begin
         if (hit >= 0) node_valid[hit] = 1'b0;
         else r.status = STATUS_NOT_FOUND;
      end else begin
         if (hit >= 0) begin
            node_seen[hit] = now_ms;
            node_live[hit] = LIVE_ALIVE;
         end else begin
            r.status = STATUS_NOT_FOUND;
         end
      end
      if (typed) r.status = typed_status;
      pending_results.push_back(r);
   endfunction

   function automatic bit sender_idles();
      if (idle_mode == IDLE_SENDER) return $urandom_range(99) < 80;
      if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 6;
      return 1'b0;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance.
   // The valid line stays high between back-to-back items.
   task automatic send_item(input logic [1:0] func, input logic [15:0] ident,
                            input logic [31:0] now_ms, input logic typed,
                            input logic [1:0] typed_status);
      while (sender_idles()) begin
         req_chan.valid = 1'b0;
         @(negedge clock);
      end
      req_chan.valid = 1'b1;
      req_chan.func = func;
      req_chan.node_ident = ident;
      req_chan.now_ms = now_ms;
      do @(posedge clock); while (!req_chan.ready);
      detector_predict(func, ident, now_ms, typed, typed_status);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   // Registers are written only with the block idle: every result in, and
   // then enough cycles for a walk that produces no further item.
   task automatic write_register(input logic index, input logic [31:0] value);
      req_chan.valid = 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = index;
      csr_write_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      if (index == REG_SUSPECT) suspect_limit = value;
      else dead_limit = value;
   endtask

   // The receiver stalls at random according to the current idle mode.
   always @(negedge clock) begin
      if (idle_mode == IDLE_RECEIVER) rsp_chan.ready = $urandom_range(99) >= 80;
      else if (idle_mode == IDLE_BOTH) rsp_chan.ready = $urandom_range(99) >= 6;
      else rsp_chan.ready = 1'b1;
   end

   // Every accepted result item is compared with the oldest expectation.
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.kind = rsp_chan.result_kind;
         got.status = rsp_chan.op_status;
         got.node = rsp_chan.changed_node;
         got.state = rsp_chan.new_state;
         got.count = rsp_chan.change_count;
         got.last = rsp_chan.last;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected item", got, '0);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) report_mismatch("wrong item", got, want);
         end
      end
   end

   // Directed rows with the default timeouts of 5000 and 15000 ms. They cover
   // the extreme ids, a silence equal to the threshold, aging one step per
   // check, dead nodes staying dead, revival of a dead node and time wrap.
   stim_row_type directed [DIRECTED_ROWS] = '{
      '{FUNC_HEARTBEAT, 16'h0005, 32'd0,          1'b1, STATUS_NOT_FOUND},
      '{FUNC_REMOVE,    16'h0005, 32'd0,          1'b1, STATUS_NOT_FOUND},
      '{FUNC_ADD,       16'h0000, 32'd0,          1'b1, STATUS_OK},
      '{FUNC_ADD,       16'hFFFF, 32'd0,          1'b1, STATUS_OK},
      '{FUNC_ADD,       16'hFFFF, 32'd100,        1'b1, STATUS_OK},
      '{FUNC_CHECK,     16'h0000, 32'd5000,       1'b0, STATUS_OK},
      '{FUNC_CHECK,     16'hFFFF, 32'd5001,       1'b0, STATUS_OK},
      '{FUNC_HEARTBEAT, 16'hFFFF, 32'd5001,       1'b1, STATUS_OK},
      '{FUNC_CHECK,     16'h0000, 32'd20001,      1'b0, STATUS_OK},
      '{FUNC_CHECK,     16'h0000, 32'hFFFF_FFFF,  1'b0, STATUS_OK},
      '{FUNC_CHECK,     16'h0000, 32'hFFFF_FFFF,  1'b0, STATUS_OK},
      '{FUNC_HEARTBEAT, 16'h0000, 32'hFFFF_FFF0,  1'b1, STATUS_OK},
      '{FUNC_CHECK,     16'h0000, 32'h0000_0010,  1'b0, STATUS_OK},
      '{FUNC_REMOVE,    16'hFFFF, 32'h0000_0020,  1'b1, STATUS_OK}
   };

   initial begin
      logic [1:0] func;
      logic [31:0] now_ms;
      logic [31:0] step_max;
      int pick;
      req_chan.valid = 1'b0;
      req_chan.func = FUNC_ADD;
      req_chan.node_ident = '0;
      req_chan.now_ms = '0;
      rsp_chan.ready = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = REG_SUSPECT;
      csr_write_data = '0;
      suspect_limit = SUSPECT_RESET;
      dead_limit = DEAD_RESET;
      for (int i = 0; i < SLOTS; i++) begin
         node_valid[i] = 1'b0;
         node_ident[i] = '0;
         node_live[i] = LIVE_ALIVE;
         node_seen[i] = '0;
      end
      // Half the pool is a known run of ids, the rest is random with the top
      // bit set and the pool position in the low bits, so all ids differ.
      for (int i = 0; i < POOL_SIZE; i++)
         id_pool[i] = (i < POOL_SIZE / 2) ? 16'h0100 + i[15:0]
                                          : {1'b1, 9'($urandom), i[5:0]};

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i])
         send_item(directed[i].func, directed[i].ident, directed[i].now_ms,
                   directed[i].typed, directed[i].status);

      // Node 0 is still in the table; fill the other 31 slots, then one more
      // add has to report a full table.
      for (int i = 0; i < SLOTS - 1; i++)
         send_item(FUNC_ADD, id_pool[i], 32'd64, 1'b0, STATUS_OK);
      send_item(FUNC_ADD, 16'h7A5A, 32'd64, 1'b1, STATUS_FULL);

      // Random phases, each with its own timeouts and idle pattern: zero
      // timeouts, the largest ones, small random ones and the defaults.
      now_ms = 32'd64;
      for (int p = 0; p < PHASES; p++) begin
         case (p % 4)
            0: begin
               write_register(REG_SUSPECT, 32'd0);
               write_register(REG_DEAD, 32'd0);
               step_max = 3;
            end
            1: begin
               write_register(REG_SUSPECT, 32'hFFFF_FFFF);
               write_register(REG_DEAD, 32'hFFFF_FFFF);
               step_max = 32'h4000_0000;
            end
            2: begin
               write_register(REG_SUSPECT, $urandom_range(400, 20));
               write_register(REG_DEAD, $urandom_range(2000, 400));
               step_max = 2500;
            end
            default: begin
               write_register(REG_SUSPECT, SUSPECT_RESET);
               write_register(REG_DEAD, DEAD_RESET);
               step_max = 20000;
            end
         endcase
         idle_mode = (p + p / 4) % 4;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Now and then the sender holds off until the block has answered
            // everything, so the block also starts from a quiet state.
            if (n == 0 || $urandom_range(99) < 5) begin
               req_chan.valid = 1'b0;
               wait_drained();
            end
            pick = $urandom_range(99);
            if (pick < 30) func = FUNC_ADD;
            else if (pick < 45) func = FUNC_REMOVE;
            else if (pick < 70) func = FUNC_HEARTBEAT;
            else func = FUNC_CHECK;
            if ($urandom_range(99) < 5) now_ms = $urandom;
            else now_ms += $urandom_range(step_max, 0);
            send_item(func,
                      ($urandom_range(99) < 8) ? 16'($urandom)
                                               : id_pool[$urandom_range(POOL_SIZE - 1)],
                      now_ms, 1'b0, STATUS_OK);
         end
      end

      req_chan.valid = 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0)
         $display("** heartbeat_failure_detector: PASSED **");
      else
         $display("** heartbeat_failure_detector: FAILED **");
      $finish;
   end

   // Far beyond the slowest correct run: every item stalled and every check
   // answering with a full table of changes.
   initial begin
      #20ms;
      $display("** heartbeat_failure_detector: FAILED **");
      $finish;
   end

endmodule
